// ----- rtl/block_rms_level_top_macros.svh -----
// Assertion macros shared by the RMS level block.
// Used by the modules that carry concurrent assertions; no other dependencies.
`ifndef BLOCK_RMS_LEVEL_TOP_MACROS_SVH
`define BLOCK_RMS_LEVEL_TOP_MACROS_SVH
// Implication checked on every rising edge outside reset.
`define RMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define RMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/rms_pkg.sv -----
// Package for the RMS level block: widths, block length and the shared cell struct.
// No dependencies.
`default_nettype none
package rms_pkg;
  localparam int SampleW  = 16;
  localparam int MagW     = 16;
  localparam int SqW      = 32;
  localparam int SumW     = 43;
  localparam int LevelW   = 15;
  localparam int QuotW    = 43;
  localparam int RootW    = 22;
  localparam int MaxBlock = 4096;
  localparam logic [LevelW-1:0] LevelMax = '1;

  // Data handed from one divide cell to the next.
  typedef struct packed {
    logic            busy;
    logic [SumW-1:0] rem;
    logic [QuotW-1:0] quot;
  } div_lane_t;
endpackage
`default_nettype wire

// ----- rtl/rms_if.sv -----
// Valid/ready channel interface carrying a parameterised payload.
// No dependencies.
`default_nettype none
interface rms_if #(parameter int W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rms_div_cell.sv -----
// One restoring divide cell: produces one quotient bit per cycle and passes
// the partial remainder on to its neighbour. Depends on rms_pkg.
`default_nettype none
module rms_div_cell #(
  parameter int CntW = 13,
  parameter int Bit  = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [CntW-1:0]     divisor,
  input  wire rms_pkg::div_lane_t  lane_in,
  output rms_pkg::div_lane_t       lane_out
);
  import rms_pkg::*;

  logic [SumW+CntW-1:0] shifted;
  logic [SumW+CntW-1:0] trial;
  logic                 fits;

  always_comb begin
    shifted = {{CntW{1'b0}}, lane_in.rem};
    trial   = {{SumW{1'b0}}, divisor} << Bit;
    fits    = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.busy <= 1'b0;
    end else begin
      lane_out.busy <= lane_in.busy;
    end
    lane_out.rem  <= fits ? SumW'(shifted - trial) : lane_in.rem;
    lane_out.quot <= lane_in.quot | (QuotW'(fits) << Bit);
  end
endmodule
`default_nettype wire

// ----- rtl/rms_sqrt.sv -----
// Iterative floor square root, two bits of the radicand per cycle,
// saturated to the 15-bit level. Depends on rms_pkg and the macro header.
`default_nettype none
`include "block_rms_level_top_macros.svh"
module rms_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [rms_pkg::QuotW-1:0] radicand,
  output logic                       done,
  output logic [rms_pkg::LevelW-1:0] level
);
  import rms_pkg::*;

  localparam int StepW = $clog2(RootW + 1);

  logic [QuotW+1:0]  rem;
  logic [QuotW+1:0]  val;
  logic [RootW-1:0]  root;
  logic [StepW-1:0]  step;
  logic              running;
  logic [QuotW+1:0]  trial;
  logic [QuotW+1:0]  rem_sh;

  always_comb begin
    rem_sh = {rem[QuotW-1:0], val[QuotW+1:QuotW]};
    trial  = {{(QuotW-RootW){1'b0}}, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= StepW'(RootW);
        rem     <= '0;
        root    <= '0;
        val     <= {1'b0, radicand, 1'b0};
      end else if (running) begin
        val <= val << 2;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RootW-2:0], 1'b0};
        end
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign level = (root > RootW'(LevelMax)) ? LevelMax : root[LevelW-1:0];

  `RMS_ASSERT_NEXT(a_done_pulse, done, !done, "sqrt done held")
  `RMS_ASSERT_IMP(a_no_restart, running, !start, "sqrt restarted while busy")
  `RMS_ASSERT_IMP(a_done_idle, done, !running, "sqrt done while running")
endmodule
`default_nettype wire

// ----- rtl/block_rms_level_top.sv -----
// Top level of the RMS level block: accumulator, divide cell chain, square root
// and output register. Depends on rms_pkg, rms_if, rms_div_cell, rms_sqrt.
//
// Usage: samples arrive on the in_ch channel (sample, last), one request per
// accepted valid/ready handshake. Samples not marked last are added to the
// accumulators as they are taken. A last sample starts the end-of-block work: a
// chain of 43 divide cells, one quotient bit per cell per cycle, then a square
// root that resolves the 22-bit root one bit per cycle. The result (rms_level,
// overflow) becomes valid on out_ch once the square root is done; in_ch.ready
// is low from the last sample until then. A result waiting on a stalled
// receiver is held in the output register, and the next block's samples are
// still taken. A further last sample waits until the previous result has been
// taken.
// Reset clears the accumulators, the flag and all valid bits; the pipeline
// chain is emptied at once.
// Samples are taken one per cycle within a block; in_ch.ready is low during
// the end-of-block work.
`default_nettype none
`include "block_rms_level_top_macros.svh"
module block_rms_level_top (
  input wire logic clk,
  input wire logic rst,
  rms_if.sink      in_ch,
  rms_if.source    out_ch
);
  import rms_pkg::*;

  localparam int CntW = $clog2(MaxBlock + 1);

  logic [SampleW-1:0] sample;
  logic               last;
  assign sample = in_ch.data[SampleW-1:0];
  assign last   = in_ch.data[SampleW];

  logic [SumW-1:0]  sum_of_squares;
  logic [CntW-1:0]  sample_count;
  logic             length_exceeded;
  logic             busy;
  logic [CntW-1:0]  div_count;
  logic [CntW-1:0]  div_sel;
  logic             flag_hold;
  logic             out_valid;
  logic [LevelW-1:0] out_level;
  logic             out_ovf;

  logic [MagW-1:0]  mag;
  logic             full;
  logic             accept;
  logic [SumW-1:0]  sum_next;
  logic [CntW-1:0]  count_next;
  logic             exceed_next;

  always_comb begin
    mag         = sample[SampleW-1] ? MagW'(-sample) : sample;
    full        = sample_count >= CntW'(MaxBlock);
    accept      = in_ch.valid && in_ch.ready;
    sum_next    = full ? sum_of_squares
                       : sum_of_squares + SumW'(SqW'(mag) * SqW'(mag));
    count_next  = full ? sample_count : sample_count + 1'b1;
    exceed_next = length_exceeded | full;
  end

  // The first cell works in the same cycle as the last sample, before the
  // count has been registered.
  assign div_sel = (accept && last) ? count_next : div_count;

  assign in_ch.ready = !busy && !(last && out_valid);

  div_lane_t lanes [0:QuotW];
  logic      sq_done;
  logic [LevelW-1:0] sq_level;

  always_comb begin
    lanes[0].busy = accept && last;
    lanes[0].rem  = sum_next;
    lanes[0].quot = '0;
  end

  genvar g;
  generate
    for (g = 0; g < QuotW; g++) begin : g_div
      rms_div_cell #(.CntW(CntW), .Bit(QuotW-1-g)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .divisor (div_sel),
        .lane_in (lanes[g]),
        .lane_out(lanes[g+1])
      );
    end
  endgenerate

  rms_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (lanes[QuotW].busy),
    .radicand(lanes[QuotW].quot),
    .done    (sq_done),
    .level   (sq_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_of_squares  <= '0;
      sample_count    <= '0;
      length_exceeded <= 1'b0;
      busy            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          sum_of_squares  <= '0;
          sample_count    <= '0;
          length_exceeded <= 1'b0;
          busy            <= 1'b1;
          div_count       <= count_next;
          flag_hold       <= exceed_next;
        end else begin
          sum_of_squares  <= sum_next;
          sample_count    <= count_next;
          length_exceeded <= exceed_next;
        end
      end
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (sq_done) begin
        busy      <= 1'b0;
        out_valid <= 1'b1;
        out_level <= sq_level;
        out_ovf   <= flag_hold;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = {out_ovf, out_level};

  `RMS_ASSERT_IMP(a_done_slot, sq_done, !out_valid, "result would overwrite pending one")
  `RMS_ASSERT_IMP(a_busy_stall, busy, !in_ch.ready, "accepting during block end")
  `RMS_ASSERT_NEXT(a_last_busy, accept && last, busy, "block end not started")
endmodule
`default_nettype wire

// ----- test/rms_level_checker.sv -----
// Checker for the RMS level block: watches both channels, predicts each level
// and compares it with what the block returns. Depends on rms_pkg and rms_if.
`timescale 1ns / 1ps
module rms_level_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [16:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_data,
  output int          fail_count,
  output int          levels_pending,
  output int          levels_seen
);
  import rms_pkg::*;

  localparam int BlockMax = MaxBlock;

  typedef struct packed {
    logic              ovf;
    logic [LevelW-1:0] level;
  } level_t;

  level_t      level_q[$];
  logic [63:0] sq_sum;
  int unsigned n_samples;
  logic        too_long;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = RootW; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Folds one sample in; returns 1 with the level when the sample ends a block.
  function automatic logic fold_sample(logic signed [15:0] s, logic lst, output level_t res);
    logic [63:0] mag;
    logic [63:0] lvl;
    mag = s[15] ? 64'(-32'(s)) : 64'(s);
    res = '0;
    if (n_samples >= BlockMax) begin
      too_long = 1'b1;
    end else begin
      sq_sum = sq_sum + mag * mag;
      n_samples++;
    end
    if (!lst) return 1'b0;
    lvl = (n_samples != 0) ? isqrt(sq_sum / n_samples) : 64'd0;
    if (lvl > 64'(LevelMax)) lvl = 64'(LevelMax);
    res.level = lvl[LevelW-1:0];
    res.ovf = too_long;
    sq_sum = 0;
    n_samples = 0;
    too_long = 1'b0;
    return 1'b1;
  endfunction

  assign levels_pending = level_q.size();

  always @(posedge clk) begin
    level_t exp_lvl;
    level_t got;
    int     errs;
    errs = 0;
    if (rst) begin
      sq_sum <= 0;
      n_samples <= 0;
      too_long <= 1'b0;
      level_q.delete();
      fail_count <= 0;
      levels_seen <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (fold_sample(in_data[15:0], in_data[16], exp_lvl)) level_q.push_back(exp_lvl);
      end
      if (out_valid && out_ready) begin
        got = out_data;
        levels_seen <= levels_seen + 1;
        if (level_q.size() == 0) begin
          $error("rms_level result with no request outstanding: %0d", got.level);
          errs++;
        end else begin
          exp_lvl = level_q.pop_front();
          if (got.level !== exp_lvl.level) begin
            $error("rms_level: expected %0d, actual %0d", exp_lvl.level, got.level);
            errs++;
          end
          if (got.ovf !== exp_lvl.ovf) begin
            $error("overflow: expected %0d, actual %0d", exp_lvl.ovf, got.ovf);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ----- test/tb.sv -----
// Testbench top for the RMS level block: clock, reset, stimulus and verdict.
// Depends on rms_pkg, rms_if, block_rms_level_top and rms_level_checker.
`timescale 1ns / 1ps
module tb;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic idle_on = 1'b1;
  int   fail_count;
  int   levels_pending;
  int   levels_seen;
  int   samples_sent = 0;
  int   blocks_sent = 0;
  int   cycles = 0;
  int   stall_left = 0;

  rms_if #(.W(17)) in_ch  (.clk(clk));
  rms_if #(.W(16)) out_ch (.clk(clk));

  block_rms_level_top DUT (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  rms_level_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .fail_count(fail_count), .levels_pending(levels_pending), .levels_seen(levels_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver stalls come in short bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_sample(logic [15:0] s, logic lst);
    logic took;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {lst, s};
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    samples_sent++;
    if (lst) blocks_sent++;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_block(int len, logic [15:0] fixed, logic use_fixed);
    for (int i = 0; i < len; i++)
      send_sample(use_fixed ? fixed : pick_sample(), i == len - 1);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    in_ch.valid <= 1'b0;
    while (levels_pending != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single-sample blocks at the extremes, then short fixed and random blocks; all -32768 must saturate the level.
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hffff, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_block(3, 16'h8000, 1'b1);
    send_block(4, 16'h7fff, 1'b1);
    send_sample(16'h0003, 1'b0);
    send_sample(16'hfffc, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_block(6, 16'h0000, 1'b0);
    wait_drained();

    while (samples_sent < 1500) begin
      if (samples_sent > 1300) idle_on = 1'b0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 100) : $urandom_range(1, 12);
      send_block(len, 16'h0000, 1'b0);
    end

    wait_drained();
    repeat (120) @(posedge clk);
    $display("Sent %0d samples in %0d blocks, %0d levels returned,", samples_sent,
             blocks_sent, levels_seen);
    $display("including full-scale blocks and stalls on both sides.");
    if (fail_count == 0 && levels_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/rms_pkg.sv
rtl/rms_if.sv
rtl/rms_div_cell.sv
rtl/rms_sqrt.sv
rtl/block_rms_level_top.sv
test/rms_level_checker.sv
test/tb.sv
